// ===== sv/wia_pkg.sv =====
// Shared types, opcodes and helpers of the word integer ALU.
package wia_pkg;

    localparam logic [5:0] OP_LOW      = 6'd0;
    localparam logic [5:0] OP_HIGH     = 6'd1;
    localparam logic [5:0] OP_COMPL    = 6'd2;
    localparam logic [5:0] OP_AND      = 6'd3;
    localparam logic [5:0] OP_OR       = 6'd4;
    localparam logic [5:0] OP_XOR      = 6'd5;
    localparam logic [5:0] OP_MAJ      = 6'd6;
    localparam logic [5:0] OP_XOR_XOR  = 6'd7;
    localparam logic [5:0] OP_CH       = 6'd8;
    localparam logic [5:0] OP_SOME     = 6'd9;
    localparam logic [5:0] OP_ALL      = 6'd10;
    localparam logic [5:0] OP_ONE      = 6'd11;
    localparam logic [5:0] OP_EQ       = 6'd12;
    localparam logic [5:0] OP_ADD      = 6'd13;
    localparam logic [5:0] OP_FULL_ADD = 6'd14;
    localparam logic [5:0] OP_FULL_INC = 6'd15;
    localparam logic [5:0] OP_INC      = 6'd16;
    localparam logic [5:0] OP_SUB      = 6'd17;
    localparam logic [5:0] OP_NEG      = 6'd18;
    localparam logic [5:0] OP_FULL_DEC = 6'd19;
    localparam logic [5:0] OP_DEC      = 6'd20;
    localparam logic [5:0] OP_FULL_SUB = 6'd21;
    localparam logic [5:0] OP_MUL      = 6'd22;
    localparam logic [5:0] OP_FULL_MUL = 6'd23;
    localparam logic [5:0] OP_IS_ZERO  = 6'd24;
    localparam logic [5:0] OP_IS_ONE   = 6'd25;
    localparam logic [5:0] OP_LE       = 6'd26;
    localparam logic [5:0] OP_LT       = 6'd27;
    localparam logic [5:0] OP_MIN      = 6'd28;
    localparam logic [5:0] OP_MAX      = 6'd29;
    localparam logic [5:0] OP_MEDIAN   = 6'd30;
    localparam logic [5:0] OP_DIV_MOD  = 6'd31;
    localparam logic [5:0] OP_DIVIDE   = 6'd32;
    localparam logic [5:0] OP_MODULO   = 6'd33;
    localparam logic [5:0] OP_DIVIDES  = 6'd34;

    localparam logic [1:0] CLS_SIMPLE = 2'd0;
    localparam logic [1:0] CLS_MUL    = 2'd1;
    localparam logic [1:0] CLS_DIV    = 2'd2;

    typedef struct packed {
        logic [5:0]  op;
        logic [1:0]  sel;
        logic        cin;
        logic [1:0]  cls;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } t_item;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } t_div_res;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        flag;
    } t_res;

    function automatic logic [63:0] word_mask(input logic [1:0] sel);
        logic [63:0] m;
        case (sel)
            2'd0: m = 64'h0000_0000_0000_00FF;
            2'd1: m = 64'h0000_0000_0000_FFFF;
            2'd2: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/wia_front.sv =====
// Front stage: takes input words, masks operands and classifies the operation.
module wia_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [5:0]      i_opcode,
    input  logic [1:0]      i_width_sel,
    input  logic            i_carry_in,
    input  logic [63:0]     i_operand_a,
    input  logic [63:0]     i_operand_b,
    input  logic [63:0]     i_operand_c,
    input  logic [63:0]     i_operand_d,
    output logic            o_valid,
    input  logic            i_ready,
    output wia_pkg::t_item  o_item
);

    logic           r_valid;
    wia_pkg::t_item r_item;
    wia_pkg::t_item n_item;
    logic [63:0]    m;

    always_comb begin
        m = wia_pkg::word_mask(i_width_sel);
        n_item.op  = i_opcode;
        n_item.sel = i_width_sel;
        n_item.cin = i_carry_in;
        n_item.a   = i_operand_a & m;
        n_item.b   = i_operand_b & m;
        n_item.c   = i_operand_c & m;
        n_item.d   = i_operand_d & m;
        case (i_opcode) inside
            wia_pkg::OP_MUL, wia_pkg::OP_FULL_MUL: n_item.cls = wia_pkg::CLS_MUL;
            wia_pkg::OP_DIV_MOD, wia_pkg::OP_DIVIDE, wia_pkg::OP_MODULO,
            wia_pkg::OP_DIVIDES: n_item.cls = wia_pkg::CLS_DIV;
            default: n_item.cls = wia_pkg::CLS_SIMPLE;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== sv/wia_fifo.sv =====
// Small register queue between the front and the back stages.
module wia_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  wia_pkg::t_item  i_item,
    output logic            o_valid,
    input  logic            i_pop,
    output wia_pkg::t_item  o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    wia_pkg::t_item  r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== sv/wia_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module wia_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [63:0]       i_dividend,
    input  logic [63:0]       i_divisor,
    output wia_pkg::t_div_res o_res
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_q;
    logic [63:0] r_d;
    logic [64:0] trial;
    logic [64:0] diff;

    assign trial = {r_rem, r_q[63]};
    assign diff  = trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == 6'd63) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_q   <= i_dividend;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            r_rem <= diff[64] ? trial[63:0] : diff[63:0];
            r_q   <= {r_q[62:0], !diff[64]};
        end
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_q;
    assign o_res.rem  = r_rem;

endmodule

// ===== sv/wia_back.sv =====
// Back end: execute stage, product sum stage and the output register.
module wia_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_pop,
    input  wia_pkg::t_item  i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output wia_pkg::t_res   o_res
);

    logic              r_a_valid;
    logic              r_a_started;
    wia_pkg::t_item    r_a;
    logic              r_b_valid;
    logic              r_b_mul;
    wia_pkg::t_res     r_b_res;
    logic [63:0]       r_b_p00;
    logic [63:0]       r_b_p01;
    logic [63:0]       r_b_p10;
    logic [63:0]       r_b_p11;
    logic [63:0]       r_b_z;
    logic [63:0]       r_b_w;
    logic              r_o_valid;
    wia_pkg::t_res     r_o;

    wia_pkg::t_div_res div_res;
    wia_pkg::t_res     a_res;
    logic              a_is_div;
    logic              div_start;
    logic              a_done;
    logic              a_adv;
    logic              a_free;
    logic              b_adv;
    logic              b_free;
    logic [63:0]       dvd;
    logic [63:0]       dvs;
    logic [63:0]       quo;
    logic [63:0]       rem;
    logic [63:0]       m;
    logic [63:0]       x;
    logic [63:0]       y;
    logic [63:0]       z;
    logic [63:0]       ad_b;
    logic              ad_c;
    logic [63:0]       sb_x;
    logic [63:0]       sb_y;
    logic              sb_c;
    logic [64:0]       sum;
    logic [64:0]       dif;
    logic              carry;
    logic [127:0]      prod;

    assign a_is_div  = (r_a.cls == wia_pkg::CLS_DIV);
    assign div_start = r_a_valid && a_is_div && !r_a_started;
    assign a_done    = !a_is_div || (r_a_started && div_res.done);
    assign b_adv     = r_b_valid && (!r_o_valid || i_ready);
    assign b_free    = !r_b_valid || b_adv;
    assign a_adv     = r_a_valid && a_done && b_free;
    assign a_free    = !r_a_valid || a_adv;
    assign o_pop     = a_free;

    assign dvd = (r_a.op == wia_pkg::OP_DIVIDES) ? r_a.b : r_a.a;
    assign dvs = (r_a.op == wia_pkg::OP_DIVIDES) ? r_a.a : r_a.b;

    wia_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_res      (div_res)
    );

    always_comb begin
        x = r_a.a;
        y = r_a.b;
        z = r_a.c;
        m = wia_pkg::word_mask(r_a.sel);
        quo = (dvs == '0) ? '0 : div_res.quo;
        rem = (dvs == '0) ? dvd : div_res.rem;
        ad_b = '0;
        ad_c = 1'b0;
        sb_x = x;
        sb_y = '0;
        sb_c = 1'b0;
        case (r_a.op)
            wia_pkg::OP_ADD: ad_b = y;
            wia_pkg::OP_FULL_ADD: begin
                ad_b = y;
                ad_c = r_a.cin;
            end
            wia_pkg::OP_FULL_INC: ad_c = r_a.cin;
            wia_pkg::OP_INC: ad_c = 1'b1;
            wia_pkg::OP_SUB: sb_y = y;
            wia_pkg::OP_NEG: begin
                sb_x = '0;
                sb_y = x;
            end
            wia_pkg::OP_FULL_DEC: sb_c = r_a.cin;
            wia_pkg::OP_DEC: sb_c = 1'b1;
            wia_pkg::OP_FULL_SUB: begin
                sb_y = y;
                sb_c = r_a.cin;
            end
            default: ad_c = 1'b0;
        endcase
        sum = {1'b0, x} + {1'b0, ad_b} + 65'(ad_c);
        dif = {1'b0, sb_x} - {1'b0, sb_y} - 65'(sb_c);
        case (r_a.sel)
            2'd0: carry = sum[8];
            2'd1: carry = sum[16];
            2'd2: carry = sum[32];
            default: carry = sum[64];
        endcase

        a_res = '0;
        case (r_a.op)
            wia_pkg::OP_LOW: a_res.lo = '0;
            wia_pkg::OP_HIGH: a_res.lo = m;
            wia_pkg::OP_COMPL: a_res.lo = ~x & m;
            wia_pkg::OP_AND: a_res.lo = x & y;
            wia_pkg::OP_OR: a_res.lo = x | y;
            wia_pkg::OP_XOR: a_res.lo = x ^ y;
            wia_pkg::OP_MAJ: a_res.lo = (x & y) | (y & z) | (z & x);
            wia_pkg::OP_XOR_XOR: a_res.lo = x ^ y ^ z;
            wia_pkg::OP_CH: a_res.lo = ((x & y) | (~x & z)) & m;
            wia_pkg::OP_SOME: a_res.flag = (x != '0);
            wia_pkg::OP_ALL: a_res.flag = (x == m);
            wia_pkg::OP_ONE: a_res.lo = 64'd1;
            wia_pkg::OP_EQ: a_res.flag = (x == y);
            wia_pkg::OP_ADD, wia_pkg::OP_FULL_ADD, wia_pkg::OP_FULL_INC,
            wia_pkg::OP_INC: begin
                a_res.lo   = sum[63:0] & m;
                a_res.flag = carry;
            end
            wia_pkg::OP_SUB, wia_pkg::OP_NEG, wia_pkg::OP_FULL_DEC,
            wia_pkg::OP_DEC, wia_pkg::OP_FULL_SUB: begin
                a_res.lo   = dif[63:0] & m;
                a_res.flag = dif[64];
            end
            wia_pkg::OP_IS_ZERO: a_res.flag = (x == '0);
            wia_pkg::OP_IS_ONE: a_res.flag = (x == 64'd1);
            wia_pkg::OP_LE: a_res.flag = (x <= y);
            wia_pkg::OP_LT: a_res.flag = (x < y);
            wia_pkg::OP_MIN: a_res.lo = (x < y) ? x : y;
            wia_pkg::OP_MAX: a_res.lo = (x < y) ? y : x;
            wia_pkg::OP_MEDIAN: begin
                if (x < y) begin
                    a_res.lo = (y < z) ? y : ((z < x) ? x : z);
                end else begin
                    a_res.lo = (x < z) ? x : ((z < y) ? y : z);
                end
            end
            wia_pkg::OP_DIV_MOD: begin
                a_res.lo = quo;
                a_res.hi = rem;
            end
            wia_pkg::OP_DIVIDE: a_res.lo = quo;
            wia_pkg::OP_MODULO: a_res.lo = rem;
            wia_pkg::OP_DIVIDES: a_res.flag = (rem == '0);
            default: a_res = '0;
        endcase
    end

    assign prod = {64'd0, r_b_p00} + {32'd0, r_b_p01, 32'd0} + {32'd0, r_b_p10, 32'd0}
                + {r_b_p11, 64'd0} + {64'd0, r_b_z} + {64'd0, r_b_w};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_a_started <= 1'b0;
            r_b_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid   <= i_valid;
                r_a_started <= 1'b0;
            end else if (div_start) begin
                r_a_started <= 1'b1;
            end
            if (b_free) begin
                r_b_valid <= a_adv;
            end
            if (!r_o_valid || i_ready) begin
                r_o_valid <= b_adv;
            end
        end
        if (a_free && i_valid) begin
            r_a <= i_item;
        end
        if (a_adv) begin
            r_b_mul <= (r_a.cls == wia_pkg::CLS_MUL);
            r_b_res <= a_res;
            r_b_p00 <= 64'(r_a.a[31:0]) * 64'(r_a.b[31:0]);
            r_b_p01 <= 64'(r_a.a[31:0]) * 64'(r_a.b[63:32]);
            r_b_p10 <= 64'(r_a.a[63:32]) * 64'(r_a.b[31:0]);
            r_b_p11 <= 64'(r_a.a[63:32]) * 64'(r_a.b[63:32]);
            r_b_z   <= (r_a.op == wia_pkg::OP_FULL_MUL) ? r_a.c : '0;
            r_b_w   <= (r_a.op == wia_pkg::OP_FULL_MUL) ? r_a.d : '0;
        end
        if (b_adv) begin
            if (r_b_mul) begin
                r_o.lo   <= prod[63:0];
                r_o.hi   <= prod[127:64];
                r_o.flag <= 1'b0;
            end else begin
                r_o <= r_b_res;
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_o;

    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> r_a_started && !div_start)
        else $error("divider started twice for one word");
    a_started_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_started |-> r_a_valid && a_is_div)
        else $error("divider marked busy without a division word");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_adv && a_is_div |-> div_res.done && r_a_started)
        else $error("division word left before the divider finished");

endmodule

// ===== sv/word_integer_alu_top.sv =====
// Top level of the word integer ALU: stream ports, front, queue and back end.
//
// Input words arrive on the s_axis channel. tuser carries the opcode and the
// width selector; tdata carries the carry bit and the four operands. Each
// input word gives exactly one output word on the m_axis channel, holding
// the low result, the high result and the flag, in input order.
// Every word passes the front register, the queue and the execute, product
// sum and output stages. Division, modulo and the divides test run through
// a restoring divider that yields one quotient bit per cycle, so they hold
// the execute stage until it is done and later words wait. Others sustain
// one word per clock while the output does not stall; the 64 by 64 product
// is built from four 32 by 32 partial products summed in the next stage.
// A queue of QUEUE_DEPTH words decouples the input side from the back end.
// Reset clears all valid flags; no word is in flight after reset.
// When the receiver stalls, the output word holds and the stall backs up
// through the stages and the queue until s_axis_tready falls.
module word_integer_alu_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // carry_in[0], operand_a[64:1], operand_b[128:65], operand_c[192:129],
    // operand_d[256:193], zero fill above
    input  logic [263:0] s_axis_tdata,
    // opcode[5:0], width_sel[7:6]
    input  logic [7:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_low[63:0], result_high[127:64], flag[128], zero fill above
    output logic [135:0] m_axis_tdata
);

    logic           fr_valid;
    logic           q_ready;
    wia_pkg::t_item fr_item;
    logic           q_valid;
    logic           q_pop;
    wia_pkg::t_item q_item;
    wia_pkg::t_res  res;

    wia_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_opcode    (s_axis_tuser[5:0]),
        .i_width_sel (s_axis_tuser[7:6]),
        .i_carry_in  (s_axis_tdata[0]),
        .i_operand_a (s_axis_tdata[64:1]),
        .i_operand_b (s_axis_tdata[128:65]),
        .i_operand_c (s_axis_tdata[192:129]),
        .i_operand_d (s_axis_tdata[256:193]),
        .o_valid     (fr_valid),
        .i_ready     (q_ready),
        .o_item      (fr_item)
    );

    wia_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .o_ready (q_ready),
        .i_item  (fr_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    wia_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_item  (q_item),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {7'd0, res.flag, res.hi, res.lo};

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench of the word integer ALU: directed and random words under varied idling.
`timescale 1ns / 1ps

module tb;

    class alu_scoreboard;
        logic [128:0] pending[$];
        int errors;
        int results_seen;
        int words_in;

        function logic [63:0] wmask(logic [1:0] sel);
            case (sel)
                2'd0: return 64'hFF;
                2'd1: return 64'hFFFF;
                2'd2: return 64'hFFFF_FFFF;
                default: return '1;
            endcase
        endfunction

        // Computes {flag, high, low} for one input word.
        function logic [128:0] alu_result(logic [5:0] op, logic [1:0] sel, logic cin,
                                          logic [63:0] a, logic [63:0] b,
                                          logic [63:0] c, logic [63:0] d);
            logic [63:0] m, x, y, z, w, r, h;
            logic [127:0] p;
            logic [64:0] s;
            logic f;
            int n;
            m = wmask(sel);
            n = 8 << sel;
            x = a & m; y = b & m; z = c & m; w = d & m;
            r = '0; h = '0; f = 1'b0; s = '0;
            case (op)
                wia_pkg::OP_LOW: r = '0;
                wia_pkg::OP_HIGH: r = m;
                wia_pkg::OP_COMPL: r = ~x & m;
                wia_pkg::OP_AND: r = x & y;
                wia_pkg::OP_OR: r = x | y;
                wia_pkg::OP_XOR: r = x ^ y;
                wia_pkg::OP_MAJ: r = (x & y) | (y & z) | (z & x);
                wia_pkg::OP_XOR_XOR: r = x ^ y ^ z;
                wia_pkg::OP_CH: r = ((x & y) | (~x & z)) & m;
                wia_pkg::OP_SOME: f = x != 0;
                wia_pkg::OP_ALL: f = x == m;
                wia_pkg::OP_ONE: r = 64'd1;
                wia_pkg::OP_EQ: f = x == y;
                wia_pkg::OP_ADD, wia_pkg::OP_FULL_ADD, wia_pkg::OP_FULL_INC,
                wia_pkg::OP_INC: begin
                    case (op)
                        wia_pkg::OP_ADD: s = {1'b0, x} + y;
                        wia_pkg::OP_FULL_ADD: s = {1'b0, x} + y + cin;
                        wia_pkg::OP_FULL_INC: s = {1'b0, x} + cin;
                        default: s = {1'b0, x} + 65'd1;
                    endcase
                    r = s[63:0] & m;
                    f = s[n];
                end
                wia_pkg::OP_SUB, wia_pkg::OP_NEG, wia_pkg::OP_FULL_DEC, wia_pkg::OP_DEC,
                wia_pkg::OP_FULL_SUB: begin
                    case (op)
                        wia_pkg::OP_SUB: s = {1'b0, x} - y;
                        wia_pkg::OP_NEG: s = 65'd0 - x;
                        wia_pkg::OP_FULL_DEC: s = {1'b0, x} - cin;
                        wia_pkg::OP_DEC: s = {1'b0, x} - 65'd1;
                        default: s = {1'b0, x} - y - cin;
                    endcase
                    r = s[63:0] & m;
                    f = s[64];
                end
                wia_pkg::OP_MUL, wia_pkg::OP_FULL_MUL: begin
                    p = 128'(x) * 128'(y);
                    if (op == wia_pkg::OP_FULL_MUL) p = p + z + w;
                    r = p[63:0]; h = p[127:64];
                end
                wia_pkg::OP_IS_ZERO: f = x == 0;
                wia_pkg::OP_IS_ONE: f = x == 1;
                wia_pkg::OP_LE: f = x <= y;
                wia_pkg::OP_LT: f = x < y;
                wia_pkg::OP_MIN: r = x < y ? x : y;
                wia_pkg::OP_MAX: r = x < y ? y : x;
                wia_pkg::OP_MEDIAN:
                    if (x < y) r = (y < z) ? y : ((z < x) ? x : z);
                    else r = (x < z) ? x : ((z < y) ? y : z);
                wia_pkg::OP_DIV_MOD: begin
                    r = (y == 0) ? '0 : x / y;
                    h = (y == 0) ? x : x % y;
                end
                wia_pkg::OP_DIVIDE: r = (y == 0) ? '0 : x / y;
                wia_pkg::OP_MODULO: r = (y == 0) ? x : x % y;
                wia_pkg::OP_DIVIDES: f = (x == 0) ? (y == 0) : (y % x == 0);
                default: ;
            endcase
            return {f, h, r};
        endfunction

        function void note_word(logic [7:0] user, logic [263:0] data);
            pending.push_back(alu_result(user[5:0], user[7:6], data[0], data[64:1],
                                         data[128:65], data[192:129], data[256:193]));
            words_in++;
        endfunction

        function void check_word(logic [135:0] data);
            logic [128:0] want;
            results_seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected output word %h", $time, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data[63:0] !== want[63:0]) begin
                $display("%0t: result_low expected %h actual %h", $time, want[63:0],
                         data[63:0]);
                errors++;
            end
            if (data[127:64] !== want[127:64]) begin
                $display("%0t: result_high expected %h actual %h", $time, want[127:64],
                         data[127:64]);
                errors++;
            end
            if (data[128] !== want[128]) begin
                $display("%0t: flag expected %b actual %b", $time, want[128], data[128]);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
    logic [263:0] s_axis_tdata;
    logic [7:0] s_axis_tuser;
    logic [135:0] m_axis_tdata;
    int send_idle_pct, recv_stall_pct;
    longint cycles = 0;
    alu_scoreboard board;

    word_integer_alu_top dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        board = new();
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function logic [63:0] rand_operand();
        case ($urandom_range(5))
            0: return 64'd0;
            1: return '1;
            2: return 64'd1;
            3: return {$urandom, $urandom} >> $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(logic [5:0] op, logic [1:0] sel, logic cin,
                             logic [63:0] a, logic [63:0] b, logic [63:0] c,
                             logic [63:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {sel, op};
        s_axis_tdata <= {7'd0, d, c, b, a, cin};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_word({sel, op}, {7'd0, d, c, b, a, cin});
    endtask

    task automatic send_random(int count);
        logic [5:0] op;
        repeat (count) begin
            op = ($urandom_range(19) == 0) ? 6'($urandom_range(63, 35))
                                           : 6'($urandom_range(34));
            send_word(op, 2'($urandom_range(3)), 1'($urandom_range(1)), rand_operand(),
                      ($urandom_range(9) == 0) ? 64'd0 : rand_operand(), rand_operand(),
                      rand_operand());
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        for (int op = 0; op <= 34; op += 2)
            send_word(6'(op), 2'(op % 4), 1'b1, '1, '1, '1, '1);
        send_word(wia_pkg::OP_DIV_MOD, 2'd3, 1'b0, 64'd77, 64'd0, 64'd0, 64'd0);
        send_word(wia_pkg::OP_DIVIDES, 2'd1, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0);
        send_word(wia_pkg::OP_DIVIDES, 2'd2, 1'b0, 64'd0, 64'd5, 64'd0, 64'd0);
        send_word(wia_pkg::OP_FULL_MUL, 2'd3, 1'b0, '1, '1, '1, '1);
        send_word(wia_pkg::OP_NEG, 2'd0, 1'b0, 64'd0, 64'd0, 64'd0, 64'd0);
        send_word(6'd63, 2'd3, 1'b1, '1, '1, '1, '1);
        send_word(wia_pkg::OP_FULL_SUB, 2'd3, 1'b1, 64'd0, '1, 64'd0, 64'd0);

        send_random(250);
        drain();
        send_idle_pct = 88;
        send_random(150);
        send_idle_pct = 0;
        recv_stall_pct = 88;
        send_random(150);
        send_idle_pct = 14;
        recv_stall_pct = 14;
        send_random(200);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(180);
        drain();

        $display("Sent %0d words over all 35 operations, unused opcodes and four widths;",
                 board.words_in);
        $display("checked %0d output words under four idling patterns.",
                 board.results_seen);
        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
